[design/fsns_pkg.sv]
// shared types, constants and helpers for the feature store search block
`default_nettype none
package fsns_pkg;

  localparam int DEF_ENTRIES    = 256;
  localparam int DEF_MAX_LENGTH = 512;
  localparam int DEF_MAX_TOPK   = 16;

  localparam int ELEMENT_BITS = 16;
  localparam int PROD_W       = 2 * ELEMENT_BITS;
  localparam int SCORE_W      = 40;
  localparam int SUM_W        = ((PROD_W > SCORE_W) ? PROD_W : SCORE_W) + 1;
  localparam int VLEN_W       = 10;
  localparam int LEN_MAX_W    = 12;
  localparam int STG_ADDR_W   = 12;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [VLEN_W-1:0] VLEN_RESET = VLEN_W'(512);

  localparam logic signed [SCORE_W-1:0] SCORE_MAX   = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MIN   = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam logic signed [SCORE_W-1:0] SCORE_EMPTY = -(SCORE_W'(1) <<< 30);

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_DEL  = 3'd1;
  localparam logic [2:0] OP_REG  = 3'd2;
  localparam logic [2:0] OP_UPD  = 3'd3;
  localparam logic [2:0] OP_NEAR = 3'd4;
  localparam logic [2:0] OP_TOPK = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SIZE     = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_DEL_BAD  = 3'd3;
  localparam logic [2:0] ST_DEL_IDLE = 3'd4;
  localparam logic [2:0] ST_UPD_IDLE = 3'd5;

  typedef struct packed {
    logic [2:0]                     op;
    logic [8:0]                     slot;
    logic signed [ELEMENT_BITS-1:0] element;
    logic                           is_last;
    logic signed [31:0]             owner_id;
    logic [4:0]                     want_count;
  } item_t;

  typedef struct packed {
    logic [2:0]                status;
    logic                      found;
    logic [7:0]                entry;
    logic signed [SCORE_W-1:0] score;
    logic signed [31:0]        hit_id;
    logic                      run_end;
  } result_t;

  typedef struct packed {
    logic [2:0]           op;
    logic [8:0]           slot;
    logic [31:0]          owner_id;
    logic [4:0]           want_count;
    logic [LEN_MAX_W-1:0] len;
    logic                 len_ok;
    logic                 bank;
  } cmd_t;

  typedef struct packed {
    logic                           we;
    logic [STG_ADDR_W-1:0]          addr;
    logic signed [ELEMENT_BITS-1:0] data;
  } stg_wr_t;

  typedef struct packed {
    logic done;
    logic bank;
    logic clearing;
  } back_stat_t;

  function automatic result_t mk_res(logic [2:0] status, logic [7:0] entry);
    result_t r;
    r         = '0;
    r.status  = status;
    r.entry   = entry;
    r.run_end = 1'b1;
    return r;
  endfunction

endpackage
`default_nettype wire

[design/feature_store_nearest_search.sv]
// top level of the feature store with dot product nearest and top-k search
//
//  channel   | signals                         | direction
//  item      | item_valid, item_ready, item    | in, one element word per handshake
//  result    | result_valid, result_ready, res | out, one result word per handshake
//  config    | cfg_we, cfg_wdata               | in, vector_length register
//
//  elements stream into one of two staging banks at one word per cycle while item_ready is high
//  ops run one at a time in the back: a search runs the single multiply-accumulate
//  over each used slot of the store in turn
//  add, register and update copy len elements, plus a scan for a free slot on add
//  after reset a table clearing pass over all ENTRIES slots holds item_ready low
//  input stalls while the bank being filled still waits on the back, or during clearing
`default_nettype none
module feature_store_nearest_search
  import fsns_pkg::*;
#(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int MAX_LENGTH = DEF_MAX_LENGTH,
  parameter int MAX_TOPK   = DEF_MAX_TOPK
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire item_t             item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output result_t                result,
  input  wire logic              cfg_we,
  input  wire logic [VLEN_W-1:0] cfg_wdata
);

  stg_wr_t    stg_wr;
  logic       push;
  cmd_t       push_cmd;
  logic       q_not_full;
  logic       q_valid;
  logic       q_pop;
  cmd_t       q_cmd;
  back_stat_t bstat;

  fsns_front #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stg_wr    (stg_wr),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_not_full(q_not_full),
    .bstat     (bstat)
  );

  fsns_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .not_full (q_not_full),
    .pop_valid(q_valid),
    .pop      (q_pop),
    .pop_cmd  (q_cmd)
  );

  fsns_back #(
    .ENTRIES   (ENTRIES),
    .MAX_LENGTH(MAX_LENGTH),
    .MAX_TOPK  (MAX_TOPK)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (q_valid),
    .cmd_pop     (q_pop),
    .cmd         (q_cmd),
    .stg_wr      (stg_wr),
    .bstat       (bstat),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

endmodule
`default_nettype wire

[design/fsns_queue.sv]
// short command queue between the front and the back
`default_nettype none
module fsns_queue
  import fsns_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      not_full,
  output logic      pop_valid,
  input  wire logic pop,
  output cmd_t      pop_cmd
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [NW-1:0] count;

  assign not_full  = (32'(count) < QUEUE_DEPTH);
  assign pop_valid = (count != '0);
  assign pop_cmd   = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (32'(wptr) == QUEUE_DEPTH - 1) ? '0 : wptr + PW'(1);
      end
      if (pop && pop_valid) begin
        rptr <= (32'(rptr) == QUEUE_DEPTH - 1) ? '0 : rptr + PW'(1);
      end
      count <= count + NW'(push) - NW'(pop && pop_valid);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> not_full)
    else $error("queue push while full");

endmodule
`default_nettype wire

[design/fsns_front.sv]
// front: takes words, stages elements, classifies and queues finished ops
`default_nettype none
module fsns_front
  import fsns_pkg::*;
#(
  parameter int MAX_LENGTH = DEF_MAX_LENGTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire item_t             item,
  input  wire logic              cfg_we,
  input  wire logic [VLEN_W-1:0] cfg_wdata,
  output stg_wr_t                stg_wr,
  output logic                   push,
  output cmd_t                   push_cmd,
  input  wire logic              q_not_full,
  input  wire back_stat_t        bstat
);

  localparam int LNW = $clog2(MAX_LENGTH + 2);

  logic [VLEN_W-1:0] vector_length;
  logic [LNW-1:0]    cnt;
  logic [LNW-1:0]    cnt_next;
  logic              bank;
  logic [1:0]        busy;
  logic              accept;

  assign item_ready = !busy[bank] && !bstat.clearing && q_not_full;
  assign accept     = item_valid && item_ready;
  assign cnt_next   = (32'(cnt) <= MAX_LENGTH) ? cnt + LNW'(1) : cnt;

  always_comb begin
    stg_wr.we   = accept && (32'(cnt) < MAX_LENGTH);
    stg_wr.addr = STG_ADDR_W'(32'(bank) * MAX_LENGTH + 32'(cnt));
    stg_wr.data = item.element;
    push                = accept && item.is_last;
    push_cmd.op         = item.op;
    push_cmd.slot       = item.slot;
    push_cmd.owner_id   = item.owner_id;
    push_cmd.want_count = item.want_count;
    push_cmd.len        = LEN_MAX_W'(cnt_next);
    push_cmd.len_ok     = (32'(cnt_next) == 32'(vector_length)) &&
                          (32'(cnt_next) <= MAX_LENGTH);
    push_cmd.bank       = bank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= VLEN_RESET;
      cnt           <= '0;
      bank          <= 1'b0;
      busy          <= '0;
    end else begin
      if (cfg_we) begin
        vector_length <= cfg_wdata;
      end
      if (bstat.done) begin
        busy[bstat.bank] <= 1'b0;
      end
      if (accept) begin
        if (item.is_last) begin
          cnt        <= '0;
          busy[bank] <= 1'b1;
          bank       <= !bank;
        end else begin
          cnt <= cnt_next;
        end
      end
    end
  end

  a_both_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (busy == 2'b11) |-> !item_ready)
    else $error("words taken with both staging banks in use");

endmodule
`default_nettype wire

[design/fsns_back.sv]
// back: slot table, vector store, dot product scan and result sequencing
`default_nettype none
module fsns_back
  import fsns_pkg::*;
#(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int MAX_LENGTH = DEF_MAX_LENGTH,
  parameter int MAX_TOPK   = DEF_MAX_TOPK
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    cmd_valid,
  output logic         cmd_pop,
  input  wire cmd_t    cmd,
  input  wire stg_wr_t stg_wr,
  output back_stat_t   bstat,
  output logic         result_valid,
  input  wire logic    result_ready,
  output result_t      result
);

  localparam int SLW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SCW = $clog2(ENTRIES + 1);
  localparam int LNW = $clog2(MAX_LENGTH + 2);
  localparam int CTW = $clog2(MAX_LENGTH + 3);
  localparam int EXW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int SAW = $clog2(2 * MAX_LENGTH);
  localparam int VDEPTH = ENTRIES * MAX_LENGTH;
  localparam int VAW = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
  localparam int KW  = $clog2(MAX_TOPK + 1);
  localparam int LIW = (MAX_TOPK > 1) ? $clog2(MAX_TOPK) : 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISP, S_LOOK, S_CHECK, S_FIND, S_FCHK, S_COPY,
    S_SRD, S_SCHK, S_DOT, S_FIN, S_ORD, S_OWN, S_OUT, S_DONE
  } state_t;

  typedef struct packed {
    logic        used;
    logic [31:0] owner;
  } tbl_t;

  state_t     state;
  cmd_t       cmd_r;
  logic [SCW-1:0] s;
  logic [CTW-1:0] c;
  logic [SLW-1:0] dst;
  logic [SLW-1:0] clr;
  logic [KW-1:0]  kc;
  logic [KW-1:0]  lst_cnt;
  logic [LIW-1:0] j;
  logic signed [SCORE_W-1:0] lst_score [MAX_TOPK];
  logic [SLW-1:0]            lst_slot  [MAX_TOPK];
  result_t    out_r;
  logic       out_last;

  logic signed [ELEMENT_BITS-1:0] stg_mem [2*MAX_LENGTH];
  logic signed [ELEMENT_BITS-1:0] vs_mem  [VDEPTH];
  tbl_t                           tbl_mem [ENTRIES];

  logic signed [ELEMENT_BITS-1:0] stg_q;
  logic signed [ELEMENT_BITS-1:0] vs_q;
  tbl_t                           tbl_q;

  logic                       d1_v;
  logic                       p_v;
  logic                       wr_v;
  logic [EXW-1:0]             wr_i;
  logic signed [PROD_W-1:0]   prod;
  logic signed [SCORE_W-1:0]  acc;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SCORE_W-1:0]  acc_next;

  logic [LNW-1:0] len;
  logic           slot_ok;
  logic [SLW-1:0] tslot;
  logic [SLW-1:0] tbl_raddr;
  logic           tbl_we;
  logic [SLW-1:0] tbl_waddr;
  tbl_t           tbl_wdata;
  logic [SAW-1:0] stg_raddr;
  logic [VAW-1:0] vs_raddr;
  logic [VAW-1:0] vs_waddr;
  logic           dot_end;
  logic           copy_end;
  logic [KW-1:0]  kc_calc;

  logic [MAX_TOPK-1:0]       ge;
  logic signed [SCORE_W-1:0] ins_score [MAX_TOPK];
  logic [SLW-1:0]            ins_slot  [MAX_TOPK];

  assign len      = LNW'(cmd_r.len);
  assign slot_ok  = (32'(cmd_r.slot) < ENTRIES);
  assign tslot    = SLW'(cmd_r.slot);
  assign dot_end  = (state == S_DOT) && (32'(c) == 32'(len) + 2);
  assign copy_end = (state == S_COPY) && (32'(c) == 32'(len));
  assign kc_calc  = (cmd_r.op == OP_NEAR) ? KW'(1) :
                    (32'(cmd_r.want_count) > MAX_TOPK) ? KW'(MAX_TOPK) :
                    KW'(cmd_r.want_count);

  assign cmd_pop        = (state == S_IDLE) && cmd_valid;
  assign bstat.done     = (state == S_DONE);
  assign bstat.bank     = cmd_r.bank;
  assign bstat.clearing = (state == S_CLEAR);
  assign result_valid   = (state == S_OUT);
  assign result         = out_r;

  always_comb begin
    case (state)
      S_LOOK:        tbl_raddr = tslot;
      S_FIND, S_SRD: tbl_raddr = SLW'(s);
      S_ORD:         tbl_raddr = lst_slot[j];
      default:       tbl_raddr = tslot;
    endcase
    tbl_we    = 1'b0;
    tbl_waddr = tslot;
    tbl_wdata = '0;
    if (state == S_CLEAR) begin
      tbl_we    = 1'b1;
      tbl_waddr = clr;
    end else if (state == S_CHECK && cmd_r.op == OP_DEL && tbl_q.used) begin
      tbl_we    = 1'b1;
      tbl_wdata = '{used: 1'b0, owner: '1};
    end else if (copy_end) begin
      tbl_we    = 1'b1;
      tbl_waddr = dst;
      tbl_wdata = '{used: 1'b1, owner: cmd_r.owner_id};
    end
    stg_raddr = SAW'(32'(cmd_r.bank) * MAX_LENGTH + 32'(c[EXW-1:0]));
    vs_raddr  = VAW'(SLW'(s)) * VAW'(MAX_LENGTH) + VAW'(c[EXW-1:0]);
    vs_waddr  = VAW'(dst) * VAW'(MAX_LENGTH) + VAW'(wr_i);
  end

  // saturating accumulate
  always_comb begin
    sum = SUM_W'(acc) + SUM_W'(prod);
    if (sum > SUM_W'(SCORE_MAX)) begin
      acc_next = SCORE_MAX;
    end else if (sum < SUM_W'(SCORE_MIN)) begin
      acc_next = SCORE_MIN;
    end else begin
      acc_next = SCORE_W'(sum);
    end
  end

  // sorted insert, equal scores place the newer (higher) slot first
  always_comb begin
    for (int p = 0; p < MAX_TOPK; p++) begin
      ge[p] = (p < 32'(lst_cnt)) && (lst_score[p] > acc);
    end
    for (int p = 0; p < MAX_TOPK; p++) begin
      if (ge[p] || p >= 32'(kc)) begin
        ins_score[p] = lst_score[p];
        ins_slot[p]  = lst_slot[p];
      end else if (p == 0) begin
        ins_score[p] = acc;
        ins_slot[p]  = SLW'(s);
      end else if (ge[(p > 0) ? p - 1 : 0]) begin
        ins_score[p] = acc;
        ins_slot[p]  = SLW'(s);
      end else begin
        ins_score[p] = lst_score[(p > 0) ? p - 1 : 0];
        ins_slot[p]  = lst_slot[(p > 0) ? p - 1 : 0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stg_wr.we) begin
      stg_mem[SAW'(stg_wr.addr)] <= stg_wr.data;
    end
    stg_q <= stg_mem[stg_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_v) begin
      vs_mem[vs_waddr] <= stg_q;
    end
    vs_q <= vs_mem[vs_raddr];
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_q <= tbl_mem[tbl_raddr];
  end

  // element pipeline: read, multiply, accumulate
  always_ff @(posedge clk) begin
    prod <= PROD_W'(stg_q * vs_q);
    wr_i <= c[EXW-1:0];
    if (state == S_DOT && c == '0) begin
      acc <= '0;
    end else if (p_v) begin
      acc <= acc_next;
    end
    if (rst) begin
      d1_v <= 1'b0;
      p_v  <= 1'b0;
      wr_v <= 1'b0;
    end else begin
      d1_v <= (state == S_DOT) && (32'(c) < 32'(len));
      p_v  <= d1_v;
      wr_v <= (state == S_COPY) && (32'(c) < 32'(len));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr     <= '0;
      kc      <= '0;
      lst_cnt <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr <= clr + SLW'(1);
          if (32'(clr) == ENTRIES - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r <= cmd;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          s <= '0;
          c <= '0;
          case (cmd_r.op)
            OP_ADD: begin
              if (!cmd_r.len_ok) begin
                out_r <= mk_res(ST_SIZE, '0);
                out_last <= 1'b1;
                state <= S_OUT;
              end else begin
                state <= S_FIND;
              end
            end
            OP_DEL: begin
              if (!slot_ok) begin
                out_r <= mk_res(ST_DEL_BAD, '0);
                out_last <= 1'b1;
                state <= S_OUT;
              end else begin
                state <= S_LOOK;
              end
            end
            OP_REG, OP_UPD: begin
              if (!slot_ok || !cmd_r.len_ok) begin
                out_r <= mk_res(ST_SIZE, '0);
                out_last <= 1'b1;
                state <= S_OUT;
              end else if (cmd_r.op == OP_UPD) begin
                state <= S_LOOK;
              end else begin
                dst   <= tslot;
                state <= S_COPY;
              end
            end
            OP_NEAR, OP_TOPK: begin
              kc      <= kc_calc;
              lst_cnt <= '0;
              if (!cmd_r.len_ok) begin
                out_r <= mk_res(ST_SIZE, '0);
                out_last <= 1'b1;
                state <= S_OUT;
              end else if (kc_calc == '0) begin
                out_r <= mk_res(ST_OK, '0);
                out_last <= 1'b1;
                state <= S_OUT;
              end else begin
                state <= S_SRD;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_LOOK: state <= S_CHECK;
        S_CHECK: begin
          out_last <= 1'b1;
          if (cmd_r.op == OP_DEL) begin
            out_r <= mk_res(tbl_q.used ? ST_OK : ST_DEL_IDLE, '0);
            state <= S_OUT;
          end else if (!tbl_q.used) begin
            out_r <= mk_res(ST_UPD_IDLE, '0);
            state <= S_OUT;
          end else begin
            dst   <= tslot;
            c     <= '0;
            state <= S_COPY;
          end
        end
        S_FIND: begin
          if (32'(s) == ENTRIES) begin
            out_r <= mk_res(ST_FULL, '0);
            out_last <= 1'b1;
            state <= S_OUT;
          end else begin
            state <= S_FCHK;
          end
        end
        S_FCHK: begin
          if (tbl_q.used) begin
            s     <= s + SCW'(1);
            state <= S_FIND;
          end else begin
            dst   <= SLW'(s);
            c     <= '0;
            state <= S_COPY;
          end
        end
        S_COPY: begin
          c <= c + CTW'(1);
          if (copy_end) begin
            out_r <= mk_res(ST_OK, (cmd_r.op == OP_ADD) ? 8'(dst) : 8'd0);
            out_last <= 1'b1;
            state <= S_OUT;
          end
        end
        S_SRD: begin
          state <= (32'(s) == ENTRIES) ? S_FIN : S_SCHK;
        end
        S_SCHK: begin
          if (tbl_q.used) begin
            c     <= '0;
            state <= S_DOT;
          end else begin
            s     <= s + SCW'(1);
            state <= S_SRD;
          end
        end
        S_DOT: begin
          c <= c + CTW'(1);
          if (dot_end) begin
            for (int p = 0; p < MAX_TOPK; p++) begin
              lst_score[p] <= ins_score[p];
              lst_slot[p]  <= ins_slot[p];
            end
            if (lst_cnt < kc) begin
              lst_cnt <= lst_cnt + KW'(1);
            end
            s     <= s + SCW'(1);
            state <= S_SRD;
          end
        end
        S_FIN: begin
          j <= '0;
          if (lst_cnt == '0) begin
            out_r <= mk_res(ST_OK, '0);
            if (cmd_r.op == OP_NEAR) begin
              out_r.score  <= SCORE_EMPTY;
              out_r.hit_id <= '1;
            end
            out_last <= 1'b1;
            state <= S_OUT;
          end else begin
            state <= S_ORD;
          end
        end
        S_ORD: state <= S_OWN;
        S_OWN: begin
          out_r.status  <= ST_OK;
          out_r.found   <= 1'b1;
          out_r.entry   <= 8'(lst_slot[j]);
          out_r.score   <= lst_score[j];
          out_r.hit_id  <= tbl_q.owner;
          out_r.run_end <= (32'(j) + 1 == 32'(lst_cnt));
          out_last      <= (32'(j) + 1 == 32'(lst_cnt));
          state         <= S_OUT;
        end
        S_OUT: begin
          if (result_ready) begin
            if (out_last) begin
              state <= S_DONE;
            end else begin
              j     <= j + LIW'(1);
              state <= S_ORD;
            end
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_list_bound: assert property (@(posedge clk) disable iff (rst) lst_cnt <= kc)
    else $error("best list longer than requested count");

  a_pipe_in_dot: assert property (@(posedge clk) disable iff (rst) p_v |-> state == S_DOT)
    else $error("product arrived outside a dot product pass");

endmodule
`default_nettype wire

[dv/tb.sv]
// testbench for the feature store with nearest and top-k dot product search
`timescale 1ns / 1ps
module tb;
  import fsns_pkg::*;

  localparam int SLOTS = 256;
  localparam int MAXLEN = 512;
  localparam int TOPK = 16;
  localparam longint SAT_HI = 64'sd549755813887;
  localparam longint SAT_LO = -64'sd549755813888;
  localparam int QUIET_LIMIT = 200000;
  localparam int SETTLE = 600;
  localparam int FILL_RAND = 0;
  localparam int FILL_MAX = 1;
  localparam int FILL_MIN = 2;
  localparam logic [2:0] OP_SIX = 3'd6;
  localparam logic [2:0] OP_SEVEN = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic cfg_we = 1'b0;
  logic [VLEN_W-1:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  feature_store_nearest_search i_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // mirror of the slot table
  shortint store_vec[SLOTS][MAXLEN];
  bit slot_on[SLOTS];
  int slot_id[SLOTS];
  shortint stage[MAXLEN];
  int stage_cnt = 0;
  int vec_len = 512;
  longint slot_sc[SLOTS];
  bit slot_taken[SLOTS];

  result_t pending_results[$];
  int fails = 0;
  bit gaps_on = 1'b1;
  bit long_hold = 1'b0;
  int quiet = 0;

  typedef struct {
    bit cfg;
    int vlen;
    logic [2:0] op;
    int slot;
    int owner;
    int want;
    int n;
    int fill;
    bit typed;
    result_t exp;
  } row_t;

  row_t plan[$];

  function automatic row_t op_row(logic [2:0] op, int slot, int owner, int want, int n,
                                  int fill);
    row_t r;
    r = '{default: 0};
    r.op = op;
    r.slot = slot;
    r.owner = owner;
    r.want = want;
    r.n = n;
    r.fill = fill;
    return r;
  endfunction

  function automatic row_t typed_row(logic [2:0] op, int slot, int n, int fill,
                                     logic [2:0] st, logic [7:0] entry);
    row_t r;
    r = op_row(op, slot, 32'h12345678, 0, n, fill);
    r.typed = 1'b1;
    r.exp = mk_res(st, entry);
    return r;
  endfunction

  function automatic row_t cfg_row(int v);
    row_t r;
    r = '{default: 0};
    r.cfg = 1'b1;
    r.vlen = v;
    return r;
  endfunction

  function automatic longint dot_score(int s);
    longint acc;
    acc = 0;
    for (int i = 0; i < vec_len && i < MAXLEN; i++) begin
      acc += longint'(store_vec[s][i]) * longint'(stage[i]);
      if (acc > SAT_HI) acc = SAT_HI;
      if (acc < SAT_LO) acc = SAT_LO;
    end
    return acc;
  endfunction

  function automatic int best_slot();
    int b;
    bit have;
    b = 0;
    have = 0;
    for (int s = 0; s < SLOTS; s++) begin
      if (slot_on[s] && !slot_taken[s] && (!have || slot_sc[s] >= slot_sc[b])) begin
        b = s;
        have = 1;
      end
    end
    slot_taken[b] = 1;
    return b;
  endfunction

  function automatic result_t hit_res(int s, bit last);
    result_t r;
    r = '0;
    r.status = ST_OK;
    r.found = 1'b1;
    r.entry = s[7:0];
    r.score = slot_sc[s][SCORE_W-1:0];
    r.hit_id = slot_id[s];
    r.run_end = last;
    return r;
  endfunction

  task automatic compute_results(item_t it);
    int len, used, k, s;
    bit ok;
    result_t r;
    if (stage_cnt < MAXLEN) stage[stage_cnt] = it.element;
    if (stage_cnt <= MAXLEN) stage_cnt++;
    if (!it.is_last) return;
    len = stage_cnt;
    stage_cnt = 0;
    ok = (len == vec_len) && (len <= MAXLEN);
    used = 0;
    for (s = 0; s < SLOTS; s++) begin
      slot_taken[s] = 0;
      if (slot_on[s]) begin
        slot_sc[s] = dot_score(s);
        used++;
      end
    end
    case (it.op)
      OP_ADD: begin
        for (s = 0; s < SLOTS; s++) if (!slot_on[s]) break;
        if (!ok) pending_results.push_back(mk_res(ST_SIZE, 0));
        else if (s >= SLOTS) pending_results.push_back(mk_res(ST_FULL, 0));
        else begin
          for (int i = 0; i < vec_len; i++) store_vec[s][i] = stage[i];
          slot_on[s] = 1;
          slot_id[s] = it.owner_id;
          pending_results.push_back(mk_res(ST_OK, s[7:0]));
        end
      end
      OP_DEL: begin
        if (it.slot >= SLOTS) pending_results.push_back(mk_res(ST_DEL_BAD, 0));
        else if (!slot_on[it.slot]) pending_results.push_back(mk_res(ST_DEL_IDLE, 0));
        else begin
          slot_on[it.slot] = 0;
          slot_id[it.slot] = -1;
          pending_results.push_back(mk_res(ST_OK, 0));
        end
      end
      OP_REG, OP_UPD: begin
        if (it.slot >= SLOTS || !ok) pending_results.push_back(mk_res(ST_SIZE, 0));
        else if (it.op == OP_UPD && !slot_on[it.slot])
          pending_results.push_back(mk_res(ST_UPD_IDLE, 0));
        else begin
          for (int i = 0; i < vec_len; i++) store_vec[it.slot][i] = stage[i];
          slot_on[it.slot] = 1;
          slot_id[it.slot] = it.owner_id;
          pending_results.push_back(mk_res(ST_OK, 0));
        end
      end
      OP_NEAR: begin
        if (!ok) pending_results.push_back(mk_res(ST_SIZE, 0));
        else if (used == 0) begin
          r = mk_res(ST_OK, 0);
          r.score = SCORE_EMPTY;
          r.hit_id = -1;
          pending_results.push_back(r);
        end else pending_results.push_back(hit_res(best_slot(), 1'b1));
      end
      OP_TOPK: begin
        k = it.want_count;
        if (k > TOPK) k = TOPK;
        if (k > used) k = used;
        if (!ok) pending_results.push_back(mk_res(ST_SIZE, 0));
        else if (k == 0) pending_results.push_back(mk_res(ST_OK, 0));
        else for (int i = 0; i < k; i++) pending_results.push_back(hit_res(best_slot(), i == k - 1));
      end
      default: ;
    endcase
  endtask

  task automatic push_word(item_t it);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    compute_results(it);
  endtask

  task automatic send_op(logic [2:0] op, int slot, int owner, int want, int n, int fill);
    item_t it;
    for (int i = 0; i < n; i++) begin
      it.op = $urandom;
      it.slot = $urandom;
      it.owner_id = $urandom;
      it.want_count = $urandom;
      it.is_last = (i == n - 1);
      case (fill)
        FILL_MAX: it.element = 16'sh7fff;
        FILL_MIN: it.element = 16'sh8000;
        default: begin
          it.element = $urandom;
          if ($urandom_range(0, 7) == 0) it.element = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        end
      endcase
      if (it.is_last) begin
        it.op = op;
        it.slot = slot;
        it.owner_id = owner;
        it.want_count = want;
      end
      push_word(it);
    end
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // empty the table so no slot holds a vector shorter than the new length
  task automatic set_length(int v);
    drain();
    for (int s = 0; s < SLOTS; s++) if (slot_on[s]) send_op(OP_DEL, s, 0, 0, 1, FILL_RAND);
    drain();
    cfg_wdata <= v[VLEN_W-1:0];
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    vec_len = v;
  endtask

  task automatic random_op();
    int r, n, slot, want, used;
    logic [2:0] op;
    used = 0;
    for (int s = 0; s < SLOTS; s++) used += slot_on[s];
    r = $urandom_range(0, 99);
    slot = $urandom_range(0, 39);
    if ($urandom_range(0, 19) == 0) slot = $urandom_range(256, 511);
    want = $urandom_range(0, 17);
    if ($urandom_range(0, 9) == 0) want = $urandom_range(0, 31);
    if (r < 25) op = (used < 32) ? OP_ADD : OP_DEL;
    else if (r < 40) op = OP_REG;
    else if (r < 50) op = OP_UPD;
    else if (r < 65) op = OP_DEL;
    else if (r < 78) op = OP_NEAR;
    else if (r < 94) op = OP_TOPK;
    else op = $urandom_range(0, 1) ? OP_SIX : OP_SEVEN;
    n = vec_len;
    if ($urandom_range(0, 9) == 0) n = $urandom_range(1, vec_len + 2);
    send_op(op, slot, $urandom, want, n, FILL_RAND);
  endtask

  task automatic cmp_field(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t mismatch %s expected %0h actual %0h", $time, name, e, a);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected word, actual %h", $time, result);
        fails++;
      end else begin
        cmp_field("status", pending_results[0].status, result.status);
        cmp_field("found", pending_results[0].found, result.found);
        cmp_field("entry", pending_results[0].entry, result.entry);
        cmp_field("score", pending_results[0].score, result.score);
        cmp_field("hit_id", pending_results[0].hit_id, result.hit_id);
        cmp_field("run_end", pending_results[0].run_end, result.run_end);
        void'(pending_results.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t timeout, %0d words outstanding", $time, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    @(negedge rst);
    forever begin
      if (long_hold) begin
        result_ready <= 1'b0;
        repeat (2000) @(posedge clk);
        long_hold = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        result_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    row_t r;
    r = typed_row(OP_NEAR, 0, MAXLEN, FILL_MIN, ST_OK, 0);
    r.exp.score = SCORE_EMPTY;
    r.exp.hit_id = -1;
    plan.push_back(typed_row(OP_DEL, 300, 1, FILL_RAND, ST_DEL_BAD, 0));
    plan.push_back(typed_row(OP_DEL, 3, 1, FILL_RAND, ST_DEL_IDLE, 0));
    plan.push_back(typed_row(OP_NEAR, 0, 1, FILL_RAND, ST_SIZE, 0));
    plan.push_back(typed_row(OP_TOPK, 0, MAXLEN, FILL_MIN, ST_OK, 0));
    plan.push_back(r);
    plan.push_back(op_row(OP_ADD, 0, 32'h7fffffff, 0, MAXLEN, FILL_MIN));
    plan.push_back(op_row(OP_REG, 255, 32'h80000000, 0, MAXLEN, FILL_MAX));
    plan.push_back(op_row(OP_NEAR, 0, 0, 0, MAXLEN, FILL_MIN));
    plan.push_back(op_row(OP_TOPK, 0, 0, 31, MAXLEN, FILL_RAND));
    plan.push_back(typed_row(OP_ADD, 0, MAXLEN + 1, FILL_RAND, ST_SIZE, 0));
    plan.push_back(op_row(OP_SIX, 0, 0, 0, 3, FILL_RAND));
    plan.push_back(op_row(OP_SEVEN, 0, 0, 0, 1, FILL_RAND));
    plan.push_back(cfg_row(0));
    plan.push_back(typed_row(OP_ADD, 0, 1, FILL_RAND, ST_SIZE, 0));
    plan.push_back(typed_row(OP_TOPK, 0, 1, FILL_RAND, ST_SIZE, 0));
    plan.push_back(cfg_row(1023));
    plan.push_back(typed_row(OP_REG, 2, 1, FILL_RAND, ST_SIZE, 0));
    plan.push_back(cfg_row(4));
    plan.push_back(typed_row(OP_UPD, 9, 4, FILL_RAND, ST_UPD_IDLE, 0));
    plan.push_back(typed_row(OP_REG, 256, 4, FILL_RAND, ST_SIZE, 0));
    plan.push_back(typed_row(OP_UPD, 511, 4, FILL_RAND, ST_SIZE, 0));
    plan.push_back(typed_row(OP_REG, 7, 4, FILL_MAX, ST_OK, 0));
    plan.push_back(typed_row(OP_REG, 3, 4, FILL_MAX, ST_OK, 0));
    plan.push_back(typed_row(OP_ADD, 0, 4, FILL_MAX, ST_OK, 0));
    plan.push_back(op_row(OP_TOPK, 0, 0, 3, 4, FILL_RAND));
    plan.push_back(op_row(OP_NEAR, 0, 0, 0, 4, FILL_MAX));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].cfg) set_length(plan[i].vlen);
      else begin
        send_op(plan[i].op, plan[i].slot, plan[i].owner, plan[i].want, plan[i].n, plan[i].fill);
        if (plan[i].typed) pending_results[$] = plan[i].exp;
      end
    end

    set_length(3);
    for (int i = 0; i < 60; i++) begin
      if (i == 20) long_hold = 1'b1;
      random_op();
    end
    set_length(8);
    for (int i = 0; i < 30; i++) random_op();
    set_length(1);
    for (int i = 0; i < 40; i++) random_op();

    // no random gaps from here on: fill the table to full, then search it and send a bad delete
    drain();
    gaps_on = 1'b0;
    set_length(1);
    for (int i = 0; i <= SLOTS; i++) send_op(OP_ADD, 0, $urandom, 0, 1, FILL_RAND);
    send_op(OP_NEAR, 0, 0, 0, 1, FILL_RAND);
    send_op(OP_TOPK, 0, 0, 16, 1, FILL_RAND);
    send_op(OP_TOPK, 0, 0, 31, 1, FILL_MIN);
    send_op(OP_DEL, 511, 0, 0, 1, FILL_RAND);

    drain();
    if (fails == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

[filelist.f]
design/fsns_pkg.sv
design/fsns_queue.sv
design/fsns_front.sv
design/fsns_back.sv
design/feature_store_nearest_search.sv
dv/tb.sv
